[design/c_style_byte_escaper_defines.svh]
// Assertion macros used by the escaper back unit.
`ifndef C_STYLE_BYTE_ESCAPER_DEFINES_SVH
`define C_STYLE_BYTE_ESCAPER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cse_pkg.sv]
package cse_pkg;

  localparam int unsigned CseQueueDepth = 2;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_SHORT,
    CLS_HEX
  } esc_class_e;

  typedef enum logic [1:0] {
    StepFirst,
    StepSecond,
    StepHexHi,
    StepHexLo
  } esc_step_e;

  typedef struct packed {
    esc_class_e cls;
    logic [7:0] raw;
    logic [7:0] esc_char;
    logic       string_end;
  } entry_t;

  localparam logic [7:0] PrintLow    = 8'd32;
  localparam logic [7:0] PrintHigh   = 8'd126;
  localparam logic [7:0] CtlTab      = 8'h09;
  localparam logic [7:0] CtlNewline  = 8'h0A;
  localparam logic [7:0] CtlReturn   = 8'h0D;
  localparam logic [7:0] CtlEscape   = 8'h1B;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerE    = 8'h65;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChUpperA    = 8'h41;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = ChZero + {4'h0, nib};
    end else begin
      res = ChUpperA + {4'h0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

[design/cse_front.sv]
module cse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      in_byte_i,
  input  logic            in_string_end_i,
  output logic            q_push_o,
  input  logic            q_full_i,
  output cse_pkg::entry_t q_entry_o
);
  import cse_pkg::*;

  logic   valid_d, valid_q;
  entry_t entry_d, entry_q;
  logic   accept;

  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_push_o = valid_q;
  assign q_entry_o = entry_q;
  assign valid_d  = accept || (valid_q && q_full_i);

  always_comb begin
    entry_d            = entry_q;
    entry_d.raw        = in_byte_i;
    entry_d.string_end = in_string_end_i;
    entry_d.esc_char   = ChLowerX;
    if (in_byte_i inside {[PrintLow:PrintHigh]}) begin
      entry_d.cls = CLS_PLAIN;
    end else begin
      case (in_byte_i)
        CtlTab: begin
          entry_d.cls      = CLS_SHORT;
          entry_d.esc_char = ChLowerT;
        end
        CtlNewline: begin
          entry_d.cls      = CLS_SHORT;
          entry_d.esc_char = ChLowerN;
        end
        CtlReturn: begin
          entry_d.cls      = CLS_SHORT;
          entry_d.esc_char = ChLowerR;
        end
        CtlEscape: begin
          entry_d.cls      = CLS_SHORT;
          entry_d.esc_char = ChLowerE;
        end
        default: begin
          entry_d.cls = CLS_HEX;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

[design/cse_queue.sv]
module cse_queue #(
  parameter int unsigned Depth = cse_pkg::CseQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  cse_pkg::entry_t entry_i,
  output logic            empty_o,
  input  logic            pop_i,
  output cse_pkg::entry_t entry_o
);
  import cse_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  entry_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_d, wr_ptr_q;
  logic [IdxW-1:0]   rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]   count_d, count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[design/cse_back.sv]
`include "c_style_byte_escaper_defines.svh"

module cse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cse_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_last_o
);
  import cse_pkg::*;

  logic       out_valid_d, out_valid_q;
  logic [7:0] out_byte_d, out_byte_q;
  logic       run_last_d, run_last_q;
  logic       string_last_d, string_last_q;
  esc_step_e  step_d, step_q, step_next;
  logic       load, emit, last;
  logic [7:0] next_char;

  assign load = !out_valid_q || pop;
  assign emit = load && !q_empty_i;

  always_comb begin
    case (step_q)
      StepFirst: begin
        next_char = (q_entry_i.cls == CLS_PLAIN) ? q_entry_i.raw : ChBackslash;
        step_next = StepSecond;
      end
      StepSecond: begin
        next_char = q_entry_i.esc_char;
        step_next = StepHexHi;
      end
      StepHexHi: begin
        next_char = hex_char(q_entry_i.raw[7:4]);
        step_next = StepHexLo;
      end
      StepHexLo: begin
        next_char = hex_char(q_entry_i.raw[3:0]);
        step_next = StepFirst;
      end
      default: begin
        next_char = ChBackslash;
        step_next = StepFirst;
      end
    endcase
    last = ((q_entry_i.cls == CLS_PLAIN) && (step_q == StepFirst)) ||
           ((q_entry_i.cls == CLS_SHORT) && (step_q == StepSecond)) ||
           (step_q == StepHexLo);
  end

  assign q_pop_o = emit && last;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_byte_d    = out_byte_q;
    run_last_d    = run_last_q;
    string_last_d = string_last_q;
    step_d        = step_q;
    if (emit) begin
      out_valid_d   = 1'b1;
      out_byte_d    = next_char;
      run_last_d    = last;
      string_last_d = last && q_entry_i.string_end;
      step_d        = last ? StepFirst : step_next;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= StepFirst;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q    <= out_byte_d;
    run_last_q    <= run_last_d;
    string_last_q <= string_last_d;
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = string_last_q;

  `CSE_ASSERT_IMP(a_str_last_in_run, out_valid_q && string_last_q, run_last_q, "string_last outside run end")
  `CSE_ASSERT_IMP(a_mid_run_has_head, step_q != StepFirst, !q_empty_i, "mid-run step without queued entry")
  `CSE_ASSERT_IMP(a_mid_run_not_plain, (step_q != StepFirst) && !q_empty_i, q_entry_i.cls != CLS_PLAIN, "plain byte left a partial run")
  `CSE_ASSERT_NXT(a_out_hold, out_valid_q && !pop, out_valid_q && $stable(out_byte_q), "held result changed")

endmodule

[design/c_style_byte_escaper.sv]
// Channel  | Handshake          | Fields
// ---------+--------------------+-----------------------------------------
// input    | push / full        | in_byte_i, in_string_end_i
// result   | pop / empty        | out_byte_o, run_last_o, string_last_o
//
// Each input byte gives one, two or four result bytes (plain, short or
// hex escape), sent one by one through the back unit's result register.
// An input transfer can be taken every cycle while the front register and
// queue have room, and it reaches the result register through the queue.
// Reset clears the valid flags, queue pointers and count, and run step only.
// A stalled result holds the back unit; the queue then fills and raises full.
module c_style_byte_escaper #(
  parameter int unsigned QueueDepth = cse_pkg::CseQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_string_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_last_o
);
  import cse_pkg::*;

  entry_t f_entry, b_entry;
  logic   f_push, q_full, q_empty, b_pop;

  cse_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte_i),
    .in_string_end_i (in_string_end_i),
    .q_push_o        (f_push),
    .q_full_i        (q_full),
    .q_entry_o       (f_entry)
  );

  cse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .full_o  (q_full),
    .entry_i (f_entry),
    .empty_o (q_empty),
    .pop_i   (b_pop),
    .entry_o (b_entry)
  );

  cse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (b_entry),
    .q_pop_o       (b_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_last_o (string_last_o)
  );

endmodule
